// ===== rtl/core/ppt_pkg.sv =====
// Shared types and codes of the promotable priority table.
// No dependencies; imported by ppt_front, ppt_back, the top and the checker.
package ppt_pkg;

    localparam int ID_W     = 6;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    // request kinds as they arrive on the port
    localparam logic [KIND_W-1:0] KIND_ADD      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PROMOTE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET_MAX  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_MAX  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd4;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADID = 2'd3;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_PROMOTE,
        OP_GET_MAX,
        OP_POP_MAX,
        OP_QUERY,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] entry_id;
    } cmd_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_EXEC,
        BS_RESP
    } back_state_t;

endpackage

// ===== rtl/core/ppt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/ppt_front.sv =====
// Front end: accepts requests, classifies the kind into an operation and
// queues them for the back end. Depends on ppt_pkg.
module ppt_front
    import ppt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [KIND_W-1:0]     kind,
    input  logic [ID_W-1:0]       entry_id,
    input  logic [DATA_WIDTH-1:0] data_in,
    output logic                  q_valid,
    output cmd_t                  q_cmd,
    output logic [DATA_WIDTH-1:0] q_data,
    input  logic                  q_pop
);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    cmd_t                  cmd_mem [QDEPTH];
    logic [DATA_WIDTH-1:0] data_mem [QDEPTH];
    logic [QAW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]        count_reg, count_next;
    cmd_t                  cmd_in;
    logic                  push;

    always_comb
    begin
        cmd_in.entry_id = entry_id;
        unique case (kind)
            KIND_ADD:     cmd_in.op = OP_ADD;
            KIND_PROMOTE: cmd_in.op = OP_PROMOTE;
            KIND_GET_MAX: cmd_in.op = OP_GET_MAX;
            KIND_POP_MAX: cmd_in.op = OP_POP_MAX;
            KIND_QUERY:   cmd_in.op = OP_QUERY;
            default:      cmd_in.op = OP_NONE;
        endcase
    end

    assign req_stall = (count_reg == QCW'(QDEPTH));
    assign push      = req_valid && !req_stall;
    assign q_valid   = (count_reg != '0);
    assign q_cmd     = cmd_mem[rd_ptr_reg];
    assign q_data    = data_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCW'(push) - QCW'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg]  <= cmd_in;
            data_mem[wr_ptr_reg] <= data_in;
        end
    end

endmodule

// ===== rtl/core/ppt_tree.sv =====
// Registered comparison tree over the entry cells; the root holds the live
// entry of highest priority, highest id on ties. No dependencies.
module ppt_tree #(
    parameter int CAPACITY       = 64,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [CAPACITY-1:0]       cell_live,
    input  logic [PRIORITY_WIDTH-1:0] cell_prio [CAPACITY],
    output logic                      root_valid,
    output logic [PRIORITY_WIDTH-1:0] root_prio,
    output logic [$clog2(CAPACITY)-1:0] root_id
);

    localparam int IW = $clog2(CAPACITY);
    localparam int P  = 1 << IW;

    // heap layout: node k has children 2k and 2k+1, leaves at P .. 2P-1
    logic                      node_v [1:2*P-1];
    logic [PRIORITY_WIDTH-1:0] node_p [1:2*P-1];
    logic [IW-1:0]             node_i [1:2*P-1];

    genvar k;
    generate
        for (k = P; k < 2 * P; k++)
        begin : g_leaf
            if (k - P < CAPACITY)
            begin : g_used
                assign node_v[k] = cell_live[k-P];
                assign node_p[k] = cell_prio[k-P];
            end
            else
            begin : g_pad
                assign node_v[k] = 1'b0;
                assign node_p[k] = '0;
            end
            assign node_i[k] = IW'(k - P);
        end

        for (k = 1; k < P; k++)
        begin : g_node
            logic take_right;

            // the right child carries the higher ids, so it wins a tie
            assign take_right = node_v[2*k+1] &&
                                (!node_v[2*k] || node_p[2*k+1] >= node_p[2*k]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    node_v[k] <= 1'b0;
                end
                else
                begin
                    node_v[k] <= node_v[2*k] || node_v[2*k+1];
                end
            end

            always_ff @(posedge clk)
            begin
                node_p[k] <= take_right ? node_p[2*k+1] : node_p[2*k];
                node_i[k] <= take_right ? node_i[2*k+1] : node_i[2*k];
            end
        end
    endgenerate

    assign root_valid = node_v[1];
    assign root_prio  = node_p[1];
    assign root_id    = node_i[1];

endmodule

// ===== rtl/core/ppt_back.sv =====
// Back end: entry cells, data RAM and the sequencer that carries out one
// queued request and holds its response. Depends on ppt_pkg and ppt_ram.
module ppt_back
    import ppt_pkg::*;
#(
    parameter int CAPACITY       = 64,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  cmd_t                        q_cmd,
    input  logic [DATA_WIDTH-1:0]       q_data,
    output logic                        q_pop,
    output logic [CAPACITY-1:0]         cell_live,
    output logic [PRIORITY_WIDTH-1:0]   cell_prio [CAPACITY],
    input  logic                        root_valid,
    input  logic [PRIORITY_WIDTH-1:0]   root_prio,
    input  logic [$clog2(CAPACITY)-1:0] root_id,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [STATUS_W-1:0]         status,
    output logic [ID_W-1:0]             result_id,
    output logic [DATA_WIDTH-1:0]       result_data,
    output logic [PRIORITY_WIDTH-1:0]   result_priority,
    output logic                        is_live
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > ID_W) ? CW : ID_W;
    localparam int LW = $clog2(IW + 1);

    back_state_t               state_reg, state_next;
    cmd_t                      cmd_reg;
    logic [DATA_WIDTH-1:0]     data_reg;
    logic [CW-1:0]             ids_used_reg;
    logic [CAPACITY-1:0]       live_reg;
    logic [PRIORITY_WIDTH-1:0] prio_reg [CAPACITY];
    logic [LW-1:0]             settle_reg;

    logic [STATUS_W-1:0]       res_status_reg, res_status_next;
    logic [ID_W-1:0]           res_id_reg, res_id_next;
    logic [DATA_WIDTH-1:0]     res_data_reg, res_data_next;
    logic [PRIORITY_WIDTH-1:0] res_prio_reg, res_prio_next;
    logic                      res_live_reg, res_live_next;
    logic                      res_ram_reg, res_ram_next;

    logic                      rsp_valid_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic [ID_W-1:0]           result_id_reg;
    logic [DATA_WIDTH-1:0]     result_data_reg;
    logic [PRIORITY_WIDTH-1:0] result_prio_reg;
    logic                      is_live_reg;

    logic [EW-1:0]             id_ext, ids_ext, root_ext;
    logic [IW-1:0]             id_idx, add_idx;
    logic                      id_in_range, id_ok, full, is_max, max_ready;
    logic [PRIORITY_WIDTH-1:0] cur_prio, inc_prio;
    logic                      add_hit, promote_hit, pop_hit, read_hit;
    logic                      exec_go, resp_load;
    logic [IW-1:0]             ram_rd_addr;
    logic [DATA_WIDTH-1:0]     ram_rd_data;

    assign id_ext      = EW'(cmd_reg.entry_id);
    assign ids_ext     = EW'(ids_used_reg);
    assign root_ext    = EW'(root_id);
    assign id_idx      = id_ext[IW-1:0];
    assign add_idx     = ids_used_reg[IW-1:0];
    assign id_in_range = (id_ext < EW'(CAPACITY));
    assign id_ok       = id_in_range && (id_ext < ids_ext) && live_reg[id_idx];
    assign cur_prio    = id_in_range ? prio_reg[id_idx] : '0;
    assign inc_prio    = (&cur_prio) ? cur_prio : cur_prio + 1'b1;
    assign full        = (ids_used_reg == CW'(CAPACITY));
    assign is_max      = (cmd_reg.op == OP_GET_MAX) || (cmd_reg.op == OP_POP_MAX);
    assign max_ready   = (settle_reg == '0);

    // operation decode and response fields
    always_comb
    begin
        add_hit         = 1'b0;
        promote_hit     = 1'b0;
        pop_hit         = 1'b0;
        read_hit        = 1'b0;
        ram_rd_addr     = id_idx;
        res_status_next = ST_OK;
        res_id_next     = cmd_reg.entry_id;
        res_data_next   = '0;
        res_prio_next   = '0;
        res_live_next   = 1'b0;
        res_ram_next    = 1'b0;
        unique case (cmd_reg.op)
            OP_ADD:
            begin
                if (full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    add_hit       = 1'b1;
                    res_id_next   = ids_ext[ID_W-1:0];
                    res_data_next = data_reg;
                    res_live_next = 1'b1;
                end
            end
            OP_PROMOTE, OP_QUERY:
            begin
                if (!id_ok)
                begin
                    res_status_next = ST_BADID;
                end
                else
                begin
                    promote_hit   = (cmd_reg.op == OP_PROMOTE);
                    read_hit      = 1'b1;
                    res_prio_next = promote_hit ? inc_prio : cur_prio;
                    res_live_next = 1'b1;
                    res_ram_next  = 1'b1;
                end
            end
            OP_GET_MAX, OP_POP_MAX:
            begin
                if (!root_valid)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    pop_hit       = (cmd_reg.op == OP_POP_MAX);
                    read_hit      = 1'b1;
                    ram_rd_addr   = root_id;
                    res_id_next   = root_ext[ID_W-1:0];
                    res_prio_next = root_prio;
                    res_live_next = !pop_hit;
                    res_ram_next  = 1'b1;
                end
            end
            default:
            begin
                res_status_next = ST_OK;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BS_EXEC;
                end
            end
            BS_EXEC:
            begin
                if (!is_max || max_ready)
                begin
                    state_next = BS_RESP;
                end
            end
            BS_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop     = (state_reg == BS_IDLE) && q_valid;
        exec_go   = (state_reg == BS_EXEC) && (!is_max || max_ready);
        resp_load = (state_reg == BS_RESP) && (!rsp_valid_reg || !rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            ids_used_reg  <= '0;
            live_reg      <= '0;
            settle_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go && add_hit)
            begin
                ids_used_reg      <= ids_used_reg + 1'b1;
                live_reg[add_idx] <= 1'b1;
            end
            if (exec_go && pop_hit)
            begin
                live_reg[root_id] <= 1'b0;
            end
            // hold off max selection until the tree has seen the last change
            if (exec_go && (add_hit || promote_hit || pop_hit))
            begin
                settle_reg <= LW'(IW);
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - 1'b1;
            end
            if (resp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg  <= q_cmd;
            data_reg <= q_data;
        end
        if (exec_go)
        begin
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_data_reg   <= res_data_next;
            res_prio_reg   <= res_prio_next;
            res_live_reg   <= res_live_next;
            res_ram_reg    <= res_ram_next;
            if (add_hit)
            begin
                prio_reg[add_idx] <= '0;
            end
            if (promote_hit)
            begin
                prio_reg[id_idx] <= inc_prio;
            end
        end
        if (resp_load)
        begin
            status_reg      <= res_status_reg;
            result_id_reg   <= res_id_reg;
            result_data_reg <= res_ram_reg ? ram_rd_data : res_data_reg;
            result_prio_reg <= res_prio_reg;
            is_live_reg     <= res_live_reg;
        end
    end

    ppt_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (exec_go && add_hit),
        .wr_addr (add_idx),
        .wr_data (data_reg),
        .rd_en   (exec_go && read_hit),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cell_live       = live_reg;
    assign cell_prio       = prio_reg;
    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign result_id       = result_id_reg;
    assign result_data     = result_data_reg;
    assign result_priority = result_prio_reg;
    assign is_live         = is_live_reg;

endmodule

// ===== rtl/core/promotable_priority_table.sv =====
// Priority table with promote: add, promote, get-max, pop-max and query over
// up to CAPACITY entries, one response per request. A two-entry request queue
// parts the front end from the back end, and a response register holds the
// result until it is taken. In the back end each request is dequeued, then
// executed, then its response is loaded. Get-max and pop-max read the root
// of a registered comparison tree of clog2(CAPACITY) levels, so straight
// after a request that changed an entry they wait in the execute state for
// the tree to settle.
// Data words sit in a RAM with one read port; ids are never reused.
// Depends on ppt_pkg, ppt_front, ppt_tree, ppt_back.
module promotable_priority_table
    import ppt_pkg::*;
#(
    parameter int CAPACITY       = 64,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [KIND_W-1:0]         kind,
    input  logic [ID_W-1:0]           entry_id,
    input  logic [DATA_WIDTH-1:0]     data_in,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic [STATUS_W-1:0]       status,
    output logic [ID_W-1:0]           result_id,
    output logic [DATA_WIDTH-1:0]     result_data,
    output logic [PRIORITY_WIDTH-1:0] result_priority,
    output logic                      is_live
);

    logic                        q_valid;
    cmd_t                        q_cmd;
    logic [DATA_WIDTH-1:0]       q_data;
    logic                        q_pop;
    logic [CAPACITY-1:0]         cell_live;
    logic [PRIORITY_WIDTH-1:0]   cell_prio [CAPACITY];
    logic                        root_valid;
    logic [PRIORITY_WIDTH-1:0]   root_prio;
    logic [$clog2(CAPACITY)-1:0] root_id;

    ppt_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .kind      (kind),
        .entry_id  (entry_id),
        .data_in   (data_in),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    ppt_tree #(
        .CAPACITY       (CAPACITY),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_tree (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_live  (cell_live),
        .cell_prio  (cell_prio),
        .root_valid (root_valid),
        .root_prio  (root_prio),
        .root_id    (root_id)
    );

    ppt_back #(
        .CAPACITY       (CAPACITY),
        .DATA_WIDTH     (DATA_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_data          (q_data),
        .q_pop           (q_pop),
        .cell_live       (cell_live),
        .cell_prio       (cell_prio),
        .root_valid      (root_valid),
        .root_prio       (root_prio),
        .root_id         (root_id),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .result_id       (result_id),
        .result_data     (result_data),
        .result_priority (result_priority),
        .is_live         (is_live)
    );

endmodule

// ===== rtl/core/ppt_checker.sv =====
// Port-level checker for the promotable priority table, bound to the top.
// Depends on ppt_pkg and promotable_priority_table.
module ppt_checker
    import ppt_pkg::*;
#(
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_stall,
    input  logic [KIND_W-1:0]         kind,
    input  logic [ID_W-1:0]           entry_id,
    input  logic [DATA_WIDTH-1:0]     data_in,
    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  logic [STATUS_W-1:0]       status,
    input  logic [ID_W-1:0]           result_id,
    input  logic [DATA_WIDTH-1:0]     result_data,
    input  logic [PRIORITY_WIDTH-1:0] result_priority,
    input  logic                      is_live
);

    logic [2:0] pending_reg, pending_next;
    logic       req_take, rsp_take;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    // count requests taken but not yet answered
    always_comb
    begin
        pending_next = pending_reg + 3'(req_take) - 3'(rsp_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(kind) &&
        $stable(entry_id) && $stable(data_in))
        else $error("stalled request changed");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
        $stable(result_id) && $stable(result_data) &&
        $stable(result_priority) && $stable(is_live))
        else $error("stalled response changed");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 3'd0)
        else $error("response without an outstanding request");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ST_OK |->
        result_data == '0 && result_priority == '0 && !is_live)
        else $error("error response carries entry fields");

    a_live_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_live |-> status == ST_OK)
        else $error("live entry reported with error status");

endmodule

bind promotable_priority_table ppt_checker #(
    .DATA_WIDTH     (DATA_WIDTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH)
) u_ppt_checker (.*);
